// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. They compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VPT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define VPT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define VPT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define VPT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/vpt_pkg.sv -----
package vpt_pkg;

   localparam int ENTRY_W   = 24;
   localparam int COORD_W   = 32;
   localparam int PROD_W    = COORD_W + ENTRY_W;
   localparam int ACC_W     = 60;
   localparam int QUO_W     = 32;
   localparam int NUM_REGS  = 8;
   localparam int REG_W     = 2 * ENTRY_W;
   localparam int CSR_IDX_W = 3;

   // Matrix register indexes; each register holds two entries of one row.
   localparam int REG_M00_M01 = 0;
   localparam int REG_M02_M03 = 1;
   localparam int REG_M10_M11 = 2;
   localparam int REG_M12_M13 = 3;
   localparam int REG_M20_M21 = 4;
   localparam int REG_M22_M23 = 5;
   localparam int REG_M30_M31 = 6;
   localparam int REG_M32_M33 = 7;

   typedef struct packed {
      logic [2:0]               neg;
      logic                     wz;
      logic [2:0][COORD_W-1:0]  pass;
   } sb_type;

   // Applies a sign to a magnitude and clamps to the signed 32-bit range.
   // big is set when the magnitude is at least 2^31.
   function automatic logic [COORD_W-1:0] sat32(input logic neg, input logic big,
                                                input logic [COORD_W-1:0] mag);
      logic [COORD_W-1:0] res;
      if (neg) begin
         if (big) res = {1'b1, {(COORD_W-1){1'b0}}};
         else     res = (~mag) + COORD_W'(1);
      end else begin
         if (big) res = {1'b0, {(COORD_W-1){1'b1}}};
         else     res = mag;
      end
      return res;
   endfunction

endpackage

// ----- hw/rtl/vpt_div.sv -----
module vpt_div import vpt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [ACC_W-1:0] num,
   input  logic [ACC_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             ovf
);

   localparam int NUM_W = ACC_W + FRAC_BITS;
   localparam int HI_W  = NUM_W - QUO_W;

   logic [NUM_W-1:0] n_full;
   logic [ACC_W-1:0] hi;

   logic [ACC_W-1:0] rem_ff [0:QUO_W];
   logic [ACC_W-1:0] den_ff [0:QUO_W];
   logic [QUO_W-1:0] low_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];
   logic             ovf_ff [0:QUO_W];

   assign n_full = {num, {FRAC_BITS{1'b0}}};
   assign hi     = ACC_W'(n_full[NUM_W-1 -: HI_W]);

   // The quotient needs no more than 32 bits unless the upper part already reaches the divisor.
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= hi;
         den_ff[0] <= den;
         low_ff[0] <= n_full[QUO_W-1:0];
         quo_ff[0] <= '0;
         ovf_ff[0] <= (hi >= den);
      end
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic [ACC_W:0] trial;
      logic [ACC_W:0] diff;
      logic           take;
      assign trial = {rem_ff[i], low_ff[i][QUO_W-1-i]};
      assign diff  = trial - {1'b0, den_ff[i]};
      assign take  = ~diff[ACC_W];
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i+1] <= take ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
            den_ff[i+1] <= den_ff[i];
            low_ff[i+1] <= low_ff[i];
            quo_ff[i+1] <= {quo_ff[i][QUO_W-2:0], take};
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
   end

   assign quo = quo_ff[QUO_W];
   assign ovf = ovf_ff[QUO_W];

endmodule

// ----- hw/rtl/vertex_perspective_transform_top.sv -----
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_in_x, req_in_y, req_in_z
// rsp_      out        rsp_valid / rsp_stall  rsp_out_x, rsp_out_y, rsp_out_z, rsp_w_zero
// csr_      in         csr_we                 csr_index, csr_wdata
//
// One vertex is taken per cycle unless a held result stalls the pipeline.
// Most of the depth is the perspective divider, a 33-stage restoring pipeline (an entry
// stage, then one quotient bit per stage), ahead of which sit multiply, sum and magnitude
// stages. The whole pipeline advances together; a stalled result holds every stage in place.
// Reset is synchronous and clears the valid bits and loads the identity matrix.
module vertex_perspective_transform_top import vpt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [COORD_W-1:0]   req_in_x,
   input  logic [COORD_W-1:0]   req_in_y,
   input  logic [COORD_W-1:0]   req_in_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COORD_W-1:0]   rsp_out_x,
   output logic [COORD_W-1:0]   rsp_out_y,
   output logic [COORD_W-1:0]   rsp_out_z,
   output logic                 rsp_w_zero,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

`include "assert_macros.svh"

   localparam int               DIV_LAT = QUO_W + 1;
   localparam int               NSTG    = 3 + DIV_LAT;
   localparam logic [REG_W-1:0] ONE_LO  = REG_W'(1) << FRAC_BITS;
   localparam logic [REG_W-1:0] ONE_HI  = ONE_LO << ENTRY_W;

   // The matrix registers. The identity is the state after reset.
   logic [REG_W-1:0] csr_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            if (r == REG_M00_M01 || r == REG_M22_M23) begin
               csr_ff[r] <= ONE_LO;
            end else if (r == REG_M10_M11 || r == REG_M32_M33) begin
               csr_ff[r] <= ONE_HI;
            end else begin
               csr_ff[r] <= '0;
            end
         end
      end else if (csr_we) begin
         csr_ff[csr_index] <= csr_wdata;
      end
   end

   // Every stage moves when the output register is free or being emptied.
   logic adv;
   logic [NSTG-1:0] vld_ff;
   logic rsp_valid_ff;

   assign adv       = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[NSTG-2:0], req_valid};
         rsp_valid_ff <= vld_ff[NSTG-1];
      end
   end

   // Stage 1: twelve products of coordinate and matrix entry, plus the translation row.
   logic signed [ENTRY_W-1:0] ent [4][4];
   logic signed [COORD_W-1:0] crd [3];
   logic signed [PROD_W-1:0]  prod_ff [3][4];
   logic signed [ENTRY_W-1:0] trn_ff [4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            ent[r][c] = csr_ff[r*2 + c/2][(c%2)*ENTRY_W +: ENTRY_W];
         end
      end
   end

   assign crd[0] = req_in_x;
   assign crd[1] = req_in_y;
   assign crd[2] = req_in_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 4; c++) begin
               prod_ff[k][c] <= PROD_W'(crd[k]) * PROD_W'(ent[k][c]);
            end
         end
         for (int c = 0; c < 4; c++) trn_ff[c] <= ent[3][c];
      end
   end

   // Stage 2: exact sums with twice the fraction bits.
   logic signed [ACC_W-1:0] acc_ff [4];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 4; c++) begin
            acc_ff[c] <= ACC_W'(prod_ff[0][c]) + ACC_W'(prod_ff[1][c]) + ACC_W'(prod_ff[2][c])
                       + (ACC_W'(trn_ff[c]) <<< FRAC_BITS);
         end
      end
   end

   // Stage 3: magnitudes, signs, the zero test on w and the undivided results.
   logic [ACC_W-1:0] mag [4];
   logic [ACC_W-1:0] shr [3];
   logic [ACC_W-1:0] mag_ff [4];
   sb_type           sb_in;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         mag[c] = acc_ff[c][ACC_W-1] ? ACC_W'(-acc_ff[c]) : ACC_W'(acc_ff[c]);
      end
      sb_in.wz = (acc_ff[3] == '0);
      for (int c = 0; c < 3; c++) begin
         shr[c]         = mag[c] >> FRAC_BITS;
         sb_in.neg[c]   = acc_ff[c][ACC_W-1] ^ acc_ff[3][ACC_W-1];
         sb_in.pass[c]  = sat32(acc_ff[c][ACC_W-1], |shr[c][ACC_W-1:COORD_W-1],
                                shr[c][COORD_W-1:0]);
      end
   end

   sb_type sb3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 4; c++) mag_ff[c] <= mag[c];
         sb3_ff <= sb_in;
      end
   end

   // Divider lanes for x, y and z, with the side information delayed alongside.
   logic [QUO_W-1:0] quo [3];
   logic             ovf [3];
   sb_type           sb_ff [DIV_LAT];

   for (genvar c = 0; c < 3; c++) begin : g_lane
      vpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .adv   (adv),
         .num   (mag_ff[c]),
         .den   (mag_ff[3]),
         .quo   (quo[c]),
         .ovf   (ovf[c])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_ff[0] <= sb3_ff;
         for (int s = 1; s < DIV_LAT; s++) sb_ff[s] <= sb_ff[s-1];
      end
   end

   // Output register: pick the undivided or the divided result and saturate.
   sb_type           sb_last;
   logic [COORD_W-1:0] res [3];
   logic [COORD_W-1:0] out_ff [3];
   logic               wz_ff;

   assign sb_last = sb_ff[DIV_LAT-1];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         res[c] = sb_last.wz ? sb_last.pass[c]
                             : sat32(sb_last.neg[c], ovf[c] | quo[c][QUO_W-1], quo[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) out_ff[c] <= res[c];
         wz_ff <= sb_last.wz;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = out_ff[0];
   assign rsp_out_y  = out_ff[1];
   assign rsp_out_z  = out_ff[2];
   assign rsp_w_zero = wz_ff;

   // A transfer in always lands in the first stage.
   `VPT_ASSERT_NXT(a_enter, clock, reset, req_valid && !req_stall, vld_ff[0])
   // A held result freezes the whole pipeline.
   `VPT_ASSERT_NXT(a_hold, clock, reset, rsp_valid_ff && rsp_stall, $stable(vld_ff))
   // A new result comes only from the last divider stage.
   `VPT_ASSERT_IMP(a_src, clock, reset, $rose(rsp_valid_ff), $past(vld_ff[NSTG-1]))

endmodule

// ----- verif/vertex_perspective_transform_checker.sv -----
module vertex_perspective_transform_checker import vpt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [COORD_W-1:0]   req_in_x,
   input  logic [COORD_W-1:0]   req_in_y,
   input  logic [COORD_W-1:0]   req_in_z,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [COORD_W-1:0]   rsp_out_x,
   input  logic [COORD_W-1:0]   rsp_out_y,
   input  logic [COORD_W-1:0]   rsp_out_z,
   input  logic                 rsp_w_zero,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   vertices_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               w_zero;
   } vertex_out_type;

   logic [REG_W-1:0] matrix_regs [NUM_REGS];
   vertex_out_type   projected_q [$];

   // Signed matrix entry for a row and column, decoded from the packed register pair.
   function automatic longint coef(int row, int col);
      logic [REG_W-1:0] word;
      word = matrix_regs[row * 2 + col / 2];
      return (col % 2) ? longint'(signed'(word[47:24])) : longint'(signed'(word[23:0]));
   endfunction

   // Signs and clamps a magnitude into the signed 32-bit range.
   function automatic logic [COORD_W-1:0] clamp32(logic neg, logic [127:0] mag);
      if (neg) return (mag >= 128'h8000_0000) ? 32'h8000_0000 : (~mag[31:0]) + 32'd1;
      return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
   endfunction

   function automatic logic [63:0] abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic vertex_out_type project_vertex(logic [COORD_W-1:0] px,
                                                     logic [COORD_W-1:0] py,
                                                     logic [COORD_W-1:0] pz);
      longint      coords [3];
      longint      acc [4];
      logic [127:0] quot;
      logic [COORD_W-1:0] res [3];
      vertex_out_type r;
      coords[0] = longint'(signed'(px));
      coords[1] = longint'(signed'(py));
      coords[2] = longint'(signed'(pz));
      for (int c = 0; c < 4; c++) begin
         acc[c] = coef(3, c) * (longint'(1) << FRAC_BITS);
         for (int k = 0; k < 3; k++) acc[c] += coords[k] * coef(k, c);
      end
      for (int c = 0; c < 3; c++) begin
         if (acc[3] != 0) begin
            // Exact quotient of A * 2^FRAC_BITS by W, truncated toward zero.
            quot = ({64'd0, abs64(acc[c])} << FRAC_BITS) / {64'd0, abs64(acc[3])};
            res[c] = clamp32((acc[c] < 0) != (acc[3] < 0), quot);
         end else begin
            res[c] = clamp32(acc[c] < 0, {64'd0, abs64(acc[c]) >> FRAC_BITS});
         end
      end
      r.x = res[0];
      r.y = res[1];
      r.z = res[2];
      r.w_zero = (acc[3] == 0);
      return r;
   endfunction

   assign vertices_in_flight = projected_q.size();

   always @(posedge clock) begin
      vertex_out_type want;
      if (reset) begin
         foreach (matrix_regs[i]) matrix_regs[i] = '0;
         matrix_regs[REG_M00_M01] = 48'd1 << FRAC_BITS;
         matrix_regs[REG_M10_M11] = 48'd1 << (FRAC_BITS + ENTRY_W);
         matrix_regs[REG_M22_M23] = 48'd1 << FRAC_BITS;
         matrix_regs[REG_M32_M33] = 48'd1 << (FRAC_BITS + ENTRY_W);
         projected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (projected_q.size() == 0) begin
               $error("result transfer with no vertex outstanding");
               fail_count++;
            end else begin
               want = projected_q.pop_front();
               if (rsp_out_x !== want.x) begin
                  $error("out_x expected %h actual %h", want.x, rsp_out_x);
                  fail_count++;
               end
               if (rsp_out_y !== want.y) begin
                  $error("out_y expected %h actual %h", want.y, rsp_out_y);
                  fail_count++;
               end
               if (rsp_out_z !== want.z) begin
                  $error("out_z expected %h actual %h", want.z, rsp_out_z);
                  fail_count++;
               end
               if (rsp_w_zero !== want.w_zero) begin
                  $error("w_zero expected %b actual %b", want.w_zero, rsp_w_zero);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            projected_q.push_back(project_vertex(req_in_x, req_in_y, req_in_z));
         if (csr_we) matrix_regs[csr_index] = csr_wdata;
      end
   end

endmodule

// ----- verif/vertex_perspective_transform_top_test.sv -----
module vertex_perspective_transform_top_test import vpt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // The whole pipeline is 37 deep, so this many idle cycles drain it fully.
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 110;
   localparam int NUM_PHASES   = 8;
   localparam logic [ENTRY_W-1:0] ENTRY_MAX = 24'h7F_FFFF;
   localparam logic [ENTRY_W-1:0] ENTRY_MIN = 24'h80_0000;
   localparam logic [ENTRY_W-1:0] ENTRY_ONE = 24'h01_0000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [COORD_W-1:0]   req_in_x = '0;
   logic [COORD_W-1:0]   req_in_y = '0;
   logic [COORD_W-1:0]   req_in_z = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COORD_W-1:0]   rsp_out_x;
   logic [COORD_W-1:0]   rsp_out_y;
   logic [COORD_W-1:0]   rsp_out_z;
   logic                 rsp_w_zero;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]     csr_wdata = '0;
   int                   fail_count;
   int                   vertices_in_flight;
   int                   cycle_count = 0;
   bit                   sender_burst = 1'b0;

   always #5 clock = ~clock;

   vertex_perspective_transform_top u_dut (.*);

   vertex_perspective_transform_checker u_checker (.*);

   // A runaway simulation is a failure in its own right.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Gap drawn before each transfer. Stretches of back-to-back traffic alternate
   // with stretches of random idling so gaps land on every pipeline phase.
   function automatic int draw_gap(bit busy);
      return busy ? 0 : $urandom_range(19, 0);
   endfunction

   // Writes one matrix register pair; only called while the pipeline is empty.
   // The caller drops the write enable after its last write.
   task automatic write_matrix(int idx, logic [REG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Offers one vertex and returns once the transfer has happened. Stall is sampled
   // on the falling edge, where it is settled, to decide whether the next rising
   // edge completes the transfer. Valid stays high from one vertex to the next when
   // no gap is drawn, so it gets a single assignment per edge.
   task automatic send_vertex(logic [COORD_W-1:0] vx, logic [COORD_W-1:0] vy,
                              logic [COORD_W-1:0] vz);
      int  gap;
      bit  taken;
      gap = draw_gap(sender_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_x  <= vx;
      req_in_y  <= vy;
      req_in_z  <= vz;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   // Coordinate generator: moderate Q16.16 values in half the draws, with full-range noise,
   // zero and the signed extremes mixed in.
   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(9, 0))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3, 4:    return $urandom();
         default: return COORD_W'(signed'($urandom_range(32'h00FF_FFFF, 0)) - 32'sh0080_0000);
      endcase
   endfunction

   function automatic logic [ENTRY_W-1:0] pick_entry();
      case ($urandom_range(7, 0))
         0:       return ENTRY_MAX;
         1:       return ENTRY_MIN;
         2:       return '0;
         3:       return ENTRY_W'($urandom());
         default: return ENTRY_W'(signed'($urandom_range(32'h0003_FFFF, 0)) - 32'sh0002_0000);
      endcase
   endfunction

   // Loads a matrix chosen by phase: the first phases cover the extremes of the
   // entries and a w column of zero, the later ones are random perspective setups.
   task automatic load_matrix(int phase);
      logic [ENTRY_W-1:0] lo;
      logic [ENTRY_W-1:0] hi;
      for (int r = 0; r < NUM_REGS; r++) begin
         case (phase)
            1: begin lo = ENTRY_MAX; hi = ENTRY_MAX; end
            2: begin lo = ENTRY_MIN; hi = ENTRY_MIN; end
            3: begin
               // Every w coefficient is zero, so each vertex passes through undivided.
               lo = pick_entry();
               hi = (r % 2) ? '0 : pick_entry();
            end
            4: begin lo = ENTRY_W'($urandom()); hi = ENTRY_W'($urandom()); end
            default: begin lo = pick_entry(); hi = pick_entry(); end
         endcase
         write_matrix(r, {hi, lo});
      end
      // Keep w mostly away from zero in the later phases by a dominant constant term.
      if (phase >= 5 && $urandom_range(1, 0))
         write_matrix(REG_M32_M33, {ENTRY_ONE, pick_entry()});
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (vertices_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Receiver: per result it draws a hold-off, then releases stall until a transfer.
   // Once, after a couple hundred results, it holds off for a long stretch while the
   // sender keeps offering, so the pipeline fills and pushes back on the input.
   initial begin
      int  hold;
      int  results_seen;
      bit  busy;
      bit  taken;
      results_seen = 0;
      busy = 1'b0;
      @(negedge reset);
      forever begin
         if (results_seen % 60 == 0) busy = ($urandom_range(2, 0) == 0);
         hold = (results_seen == 200) ? HOLD_CYCLES : (busy ? 0 : $urandom_range(19, 0));
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do begin
            @(negedge clock);
            taken = rsp_valid;
            @(posedge clock);
         end while (!taken);
         results_seen++;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed vertices through the identity matrix loaded at reset: zero, each coordinate
      // at its extremes, all of them together, and one vertex of small mixed values.
      send_vertex('0, '0, '0);
      send_vertex(32'h7FFF_FFFF, '0, '0);
      send_vertex(32'h8000_0000, '0, '0);
      send_vertex('0, 32'h7FFF_FFFF, '0);
      send_vertex('0, 32'h8000_0000, '0);
      send_vertex('0, '0, 32'h7FFF_FFFF);
      send_vertex('0, '0, 32'h8000_0000);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000);
      req_valid <= 1'b0;
      wait_drained();

      // A perspective matrix with w = z: z = 0 gives a zero w and the pass-through
      // path, a tiny z drives the quotient into saturation, and z = -1 flips signs.
      write_matrix(REG_M32_M33, '0);
      write_matrix(REG_M22_M23, {ENTRY_ONE, ENTRY_ONE});
      csr_we <= 1'b0;
      send_vertex(32'h0001_0000, 32'h0002_0000, '0);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, '0);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      send_vertex(32'h0003_0000, 32'h0005_0000, 32'hFFFF_0000);
      send_vertex(32'h0007_0000, 32'hFFF9_0000, 32'h0003_0000);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      req_valid <= 1'b0;
      wait_drained();

      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         load_matrix(phase);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) sender_burst = ($urandom_range(2, 0) == 0);
            // Keep offering back to back while the receiver's long hold-off is likely.
            if (phase == 2 && i >= 60) sender_burst = 1'b1;
            send_vertex(pick_coord(), pick_coord(), pick_coord());
         end
         req_valid <= 1'b0;
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
